### rtl/core/cam_cap_pkg.sv
// Shared types and constants for the camera sync line/frame capture block.
// Word layouts for the input and result streams, counter limits.
// No dependencies.
package cam_cap_pkg;

	localparam int LINE_MAX  = 2048;
	localparam int MAX_LINES = 4096;

	localparam int COL_W   = 11;
	localparam int LINES_W = 12;

	localparam int COL_CAP_I   = (LINE_MAX - 1 > 2047) ? 2047 : LINE_MAX - 1;
	localparam int LINES_CAP_I = (MAX_LINES - 1 > 4095) ? 4095 : MAX_LINES - 1;

	localparam logic [COL_W-1:0]   COL_CAP   = COL_W'(COL_CAP_I);
	localparam logic [LINES_W-1:0] LINES_CAP = LINES_W'(LINES_CAP_I);

	localparam int IN_W  = 16;
	localparam int OUT_W = 48;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_ARM    = 1'b1
	} op_t;

	// input word, lowest bit first: href, vsync, data_byte
	typedef struct packed {
		logic [5:0] pad;
		logic [7:0] data_byte;
		logic       vsync;
		logic       href;
	} in_word_t;

	// result word, lowest bit first: pixel_valid .. capturing
	typedef struct packed {
		logic               pad;
		logic               capturing;
		logic [LINES_W-1:0] frame_lines;
		logic               frame_done;
		logic [COL_W-1:0]   line_width;
		logic               line_captured;
		logic               line_done;
		logic [COL_W-1:0]   pixel_column;
		logic [7:0]         pixel_byte;
		logic               pixel_valid;
	} res_word_t;

endpackage

### rtl/core/camera_sync_line_frame_capture.sv
// Throughput: one word per cycle while s_tready is high; the edge detect and counters
// update in one pass. A two-entry result buffer (output register plus skid) registers
// each result word and takes one accepted under an m_tready stall; s_tready is low
// while the skid is full. Reset (arst_n low) sets the previous href and vsync levels
// to one, clears counters, arm and capture flags, and empties the buffer.
// Depends on cam_cap_pkg.
module camera_sync_line_frame_capture (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cam_cap_pkg::IN_W-1:0] s_tdata,   // href, vsync, data_byte[7:0], zero pad
	input  logic                         s_tuser,   // op
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cam_cap_pkg::OUT_W-1:0] m_tdata   // pixel_valid, pixel_byte[7:0],
	// pixel_column[10:0], line_done, line_captured, line_width[10:0], frame_done,
	// frame_lines[11:0], capturing, zero pad
);
	import cam_cap_pkg::*;

	logic               line_valid_prev_q;
	logic               frame_sync_prev_q;
	logic [COL_W-1:0]   column_count_q;
	logic [LINES_W-1:0] line_count_q;
	logic               capture_armed_q;
	logic               capture_active_q;

	logic               lv_n;
	logic               fs_n;
	logic [COL_W-1:0]   col_n;
	logic [LINES_W-1:0] lines_n;
	logic               armed_n;
	logic               active_n;

	in_word_t  in_w;
	res_word_t res;
	res_word_t out_q;
	res_word_t skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;
	logic      accept;
	logic      pop;

	assign in_w     = in_word_t'(s_tdata);
	assign s_tready = ~skid_valid_q;
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;
	assign pop      = out_valid_q & m_tready;
	assign m_tdata  = OUT_W'(out_q);

	always_comb begin
		lv_n     = line_valid_prev_q;
		fs_n     = frame_sync_prev_q;
		col_n    = column_count_q;
		lines_n  = line_count_q;
		armed_n  = capture_armed_q;
		active_n = capture_active_q;
		res      = '0;
		unique case (op_t'(s_tuser))
			OP_ARM: begin
				armed_n = 1'b1;
			end
			OP_SAMPLE: begin
				if (!in_w.vsync) begin
					if (!in_w.href && line_valid_prev_q) begin
						res.line_done     = 1'b1;
						res.line_captured = capture_active_q;
						res.line_width    = column_count_q;
						col_n             = '0;
					end else if (in_w.href && !line_valid_prev_q) begin
						if (line_count_q < LINES_CAP)
							lines_n = line_count_q + LINES_W'(1);
					end
					if (in_w.href) begin
						res.pixel_valid  = capture_active_q;
						res.pixel_byte   = in_w.data_byte;
						res.pixel_column = column_count_q;
						if (column_count_q < COL_CAP)
							col_n = column_count_q + COL_W'(1);
					end
				end
				if (in_w.vsync && !frame_sync_prev_q) begin
					res.frame_done  = 1'b1;
					res.frame_lines = line_count_q;
					lines_n         = '0;
					active_n        = 1'b0;
				end else if (!in_w.vsync && frame_sync_prev_q) begin
					active_n = capture_armed_q;
					armed_n  = 1'b0;
				end
				lv_n = in_w.href;
				fs_n = in_w.vsync;
			end
			default: begin
			end
		endcase
		res.capturing = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_prev_q <= 1'b1;
			frame_sync_prev_q <= 1'b1;
			column_count_q    <= '0;
			line_count_q      <= '0;
			capture_armed_q   <= 1'b0;
			capture_active_q  <= 1'b0;
		end else if (accept) begin
			line_valid_prev_q <= lv_n;
			frame_sync_prev_q <= fs_n;
			column_count_q    <= col_n;
			line_count_q      <= lines_n;
			capture_armed_q   <= armed_n;
			capture_active_q  <= active_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (skid_valid_q) begin
				if (pop) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (!out_valid_q || pop)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (accept) begin
			if (!out_valid_q || pop)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

endmodule

### bench/capture_checker.sv
// Checker for the camera sync line/frame capture block: watches both streams,
// predicts each result word from the accepted input words and compares them in order.
// Depends on cam_cap_pkg.
module capture_checker
	import cam_cap_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tuser,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	output int               fails,
	output int               pending
);

	logic               href_prev, vsync_prev, armed, active;
	logic [COL_W-1:0]   col_cnt;
	logic [LINES_W-1:0] line_cnt;
	res_word_t          expected_words[$];
	int                 fail_total = 0;
	int                 waiting = 0;

	assign fails   = fail_total;
	assign pending = waiting;

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		in_word_t  w;
		res_word_t r;
		res_word_t want;
		if (!arst_n) begin
			href_prev  = 1'b1;
			vsync_prev = 1'b1;
			col_cnt    = '0;
			line_cnt   = '0;
			armed      = 1'b0;
			active     = 1'b0;
			expected_words.delete();
			waiting = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				w = in_word_t'(s_tdata);
				r = '0;
				if (op_t'(s_tuser) == OP_ARM) begin
					armed = 1'b1;
				end else begin
					if (!w.vsync) begin
						if (!w.href && href_prev) begin
							r.line_done     = 1'b1;
							r.line_captured = active;
							r.line_width    = col_cnt;
							col_cnt         = '0;
						end else if (w.href && !href_prev) begin
							if (line_cnt < LINES_CAP)
								line_cnt++;
						end
						if (w.href) begin
							r.pixel_valid  = active;
							r.pixel_byte   = w.data_byte;
							r.pixel_column = col_cnt;
							if (col_cnt < COL_CAP)
								col_cnt++;
						end
					end
					if (w.vsync && !vsync_prev) begin
						r.frame_done  = 1'b1;
						r.frame_lines = line_cnt;
						line_cnt      = '0;
						active        = 1'b0;
					end else if (!w.vsync && vsync_prev) begin
						active = armed;
						armed  = 1'b0;
					end
					href_prev  = w.href;
					vsync_prev = w.vsync;
				end
				r.capturing = active;
				expected_words.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				r = res_word_t'(m_tdata);
				if (expected_words.size() == 0) begin
					$display("%0t unexpected result word: expected none actual %h",
						$time, m_tdata);
					fail_total++;
				end else begin
					want = expected_words.pop_front();
					check_field("pixel_valid", 32'(want.pixel_valid), 32'(r.pixel_valid));
					check_field("pixel_byte", 32'(want.pixel_byte), 32'(r.pixel_byte));
					check_field("pixel_column", 32'(want.pixel_column),
						32'(r.pixel_column));
					check_field("line_done", 32'(want.line_done), 32'(r.line_done));
					check_field("line_captured", 32'(want.line_captured),
						32'(r.line_captured));
					check_field("line_width", 32'(want.line_width), 32'(r.line_width));
					check_field("frame_done", 32'(want.frame_done), 32'(r.frame_done));
					check_field("frame_lines", 32'(want.frame_lines),
						32'(r.frame_lines));
					check_field("capturing", 32'(want.capturing), 32'(r.capturing));
				end
			end
			waiting = expected_words.size();
		end
	end

endmodule

### bench/tb.sv
// Top of the camera capture testbench: clock, reset, sensor-like word stimulus
// with random stalls on both streams, and the verdict.
// Depends on cam_cap_pkg, capture_checker and camera_sync_line_frame_capture.
module tb;
	import cam_cap_pkg::*;

	localparam int LIMIT = 400000;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             s_tuser  = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	int               fails, pending;
	int               cycles = 0;
	int               samples_sent = 0;
	bit               quiet = 1'b0;

	camera_sync_line_frame_capture u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	capture_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.fails   (fails),
		.pending (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 8);
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic push_word(input op_t op, input logic href, input logic vsync,
			input logic [7:0] dbyte);
		in_word_t w;
		w = '0;
		w.href      = href;
		w.vsync     = vsync;
		w.data_byte = dbyte;
		while (!quiet && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_SAMPLE)
			samples_sent++;
	endtask

	task automatic send_frame(input int n_lines, input int w_lo, input int w_hi,
			input bit noisy);
		int  blank;
		int  gap;
		int  width;
		bit  cut;
		blank = $urandom_range(1, 4);
		repeat (blank)
			push_word(OP_SAMPLE, noisy ? 1'($urandom_range(0, 1)) : 1'b0, 1'b1,
				8'($urandom));
		if (!noisy || $urandom_range(0, 99) < 60) begin
			push_word(OP_ARM, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				8'($urandom));
			if (noisy && $urandom_range(0, 3) == 0)
				push_word(OP_ARM, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					8'($urandom));
		end
		for (int l = 0; l < n_lines; l++) begin
			gap = noisy ? $urandom_range(0, 3) : 1;
			repeat (gap)
				push_word(OP_SAMPLE, 1'b0, 1'b0, 8'($urandom));
			width = $urandom_range(w_lo, w_hi);
			repeat (width)
				push_word(OP_SAMPLE, 1'b1, 1'b0, 8'($urandom));
			if (noisy && $urandom_range(0, 99) < 5)
				push_word(OP_ARM, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					8'($urandom));
		end
		cut = noisy && $urandom_range(0, 99) < 15;
		if (!cut)
			push_word(OP_SAMPLE, 1'b0, 1'b0, 8'($urandom));
		push_word(OP_SAMPLE, cut, 1'b1, 8'($urandom));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// arm twice, then href activity while between frames is ignored
		push_word(OP_ARM, 1'b1, 1'b0, 8'hFF);
		push_word(OP_ARM, 1'b0, 1'b1, 8'h00);
		push_word(OP_SAMPLE, 1'b0, 1'b1, 8'h12);
		push_word(OP_SAMPLE, 1'b1, 1'b1, 8'hFF);
		// byte on the frame start edge uses the old capture state
		push_word(OP_SAMPLE, 1'b1, 1'b0, 8'h00);
		push_word(OP_SAMPLE, 1'b1, 1'b0, 8'hFF);
		push_word(OP_SAMPLE, 1'b0, 1'b0, 8'h34);
		// arm during a frame carries to the next one
		push_word(OP_ARM, 1'b1, 1'b1, 8'hA5);
		push_word(OP_SAMPLE, 1'b1, 1'b0, 8'hAA);
		push_word(OP_SAMPLE, 1'b0, 1'b0, 8'h55);
		push_word(OP_SAMPLE, 1'b0, 1'b1, 8'h00);
		push_word(OP_SAMPLE, 1'b0, 1'b0, 8'h01);
		push_word(OP_SAMPLE, 1'b1, 1'b0, 8'h55);
		push_word(OP_SAMPLE, 1'b0, 1'b0, 8'h80);
		push_word(OP_SAMPLE, 1'b0, 1'b1, 8'h7F);
		// uncaptured frame, href rises between frames then stays high
		push_word(OP_SAMPLE, 1'b0, 1'b0, 8'hFE);
		push_word(OP_SAMPLE, 1'b1, 1'b0, 8'h80);
		push_word(OP_SAMPLE, 1'b0, 1'b0, 8'h02);
		push_word(OP_SAMPLE, 1'b1, 1'b1, 8'h03);
		push_word(OP_SAMPLE, 1'b1, 1'b0, 8'h04);
		push_word(OP_SAMPLE, 1'b0, 1'b0, 8'h08);
		push_word(OP_SAMPLE, 1'b1, 1'b1, 8'h10);

		while (samples_sent < 640) begin
			quiet = (samples_sent > 250 && samples_sent < 400);
			if ($urandom_range(0, 99) < 80) begin
				send_frame($urandom_range(1, 4), 1, 12, 1'b1);
			end else begin
				repeat ($urandom_range(1, 10))
					push_word(op_t'($urandom_range(0, 9) == 0),
						1'($urandom_range(0, 1)),
						$urandom_range(0, 99) < 60, 8'($urandom));
			end
		end
		quiet = 1'b0;

		send_frame(2, 1, 5, 1'b1);

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/core/cam_cap_pkg.sv
rtl/core/camera_sync_line_frame_capture.sv
bench/capture_checker.sv
bench/tb.sv
